@@ rtl/rtgc_pkg.sv @@
// ----------------------------------------------------------------------------
// rtgc_pkg
// Shared types and constants for the rank to grid coordinate mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package rtgc_pkg;

   localparam int unsigned EXTENT_W     = 10;
   localparam int unsigned RANK_W       = 30;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned DIV_W        = 30;
   localparam int unsigned DIV_SHORT_W  = 10;
   localparam int unsigned DIV_CNT_W    = 5;
   localparam int unsigned TRIAL_W      = 6;
   localparam int unsigned MUL_A_W      = 20;

   localparam logic [EXTENT_W-1:0] EXTENT_LIMIT = 10'd1023;

   localparam logic [CSR_INDEX_W-1:0] REG_GRID_SIZE_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_SIZE_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_SIZE_Z = 2'd2;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SIZE_XY,
      S_SIZE_Z,
      S_CHECK,
      S_LEVEL,
      S_TRIAL,
      S_TRIAL_WAIT,
      S_RED_WAIT,
      S_CSIZE_WAIT,
      S_Q_WAIT,
      S_ACC
   } state_type;

   typedef struct packed {
      logic start;
      logic wide;
   } div_req_type;

endpackage

`default_nettype wire

@@ rtl/rank_to_grid_coordinates.sv @@
// ----------------------------------------------------------------------------
// rank_to_grid_coordinates
// Maps a linear rank onto x, y, z grid coordinates by repeated prime splits.
// ----------------------------------------------------------------------------
// Throughput: one transaction at a time; busy stays high until the result.
// Result: rsp_strobe pulses for one cycle; the receiver cannot stall.
// Reset: synchronous; grid extents return to 1 and the block goes idle.
`default_nettype none

module rank_to_grid_coordinates (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [rtgc_pkg::RANK_W-1:0]       req_process_rank,
   output logic                                   rsp_strobe,
   output logic [rtgc_pkg::EXTENT_W-1:0]          rsp_coord_x,
   output logic [rtgc_pkg::EXTENT_W-1:0]          rsp_coord_y,
   output logic [rtgc_pkg::EXTENT_W-1:0]          rsp_coord_z,
   output logic                                   rsp_rank_out_of_range,
   input  wire logic                              csr_we,
   input  wire logic [rtgc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [rtgc_pkg::EXTENT_W-1:0]     csr_wdata
);
   import rtgc_pkg::*;

   state_type            state_ff, state_in;
   logic [EXTENT_W-1:0]  grid_x_ff, grid_x_in;
   logic [EXTENT_W-1:0]  grid_y_ff, grid_y_in;
   logic [EXTENT_W-1:0]  grid_z_ff, grid_z_in;
   logic [EXTENT_W-1:0]  ext_x_ff, ext_x_in;
   logic [EXTENT_W-1:0]  ext_y_ff, ext_y_in;
   logic [EXTENT_W-1:0]  ext_z_ff, ext_z_in;
   logic [EXTENT_W-1:0]  coord_x_ff, coord_x_in;
   logic [EXTENT_W-1:0]  coord_y_ff, coord_y_in;
   logic [EXTENT_W-1:0]  coord_z_ff, coord_z_in;
   logic [RANK_W-1:0]    rank_ff, rank_in;
   logic [RANK_W-1:0]    size_ff, size_in;
   axis_type             axis_ff, axis_in;
   logic [EXTENT_W-1:0]  n_ff, n_in;
   logic [TRIAL_W-1:0]   d_ff, d_in;
   logic [EXTENT_W-1:0]  best_ff, best_in;
   logic [EXTENT_W-1:0]  p_ff, p_in;
   logic [EXTENT_W-1:0]  reduced_ff, reduced_in;
   logic [EXTENT_W-1:0]  q_ff, q_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [EXTENT_W-1:0]  rsp_x_ff, rsp_x_in;
   logic [EXTENT_W-1:0]  rsp_y_ff, rsp_y_in;
   logic [EXTENT_W-1:0]  rsp_z_ff, rsp_z_in;
   logic                 rsp_oor_ff, rsp_oor_in;

   logic [MUL_A_W-1:0]          mul_a;
   logic [EXTENT_W-1:0]         mul_b;
   logic [RANK_W-1:0]           mul_p;
   logic [2*TRIAL_W-1:0]        d_sq;
   logic [EXTENT_W-1:0]         ext_sel;
   logic [EXTENT_W-1:0]         p_pick;
   logic [EXTENT_W-1:0]         csr_value;
   axis_type                    axis_pick;
   div_req_type                 div_req;
   logic [DIV_W-1:0]            div_dividend;
   logic [DIV_W-1:0]            div_divisor;
   logic                        div_done;
   logic [DIV_W-1:0]            div_quotient;
   logic [DIV_W-1:0]            div_remainder;

   rtgc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .req       (div_req),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign mul_p = {{(RANK_W-MUL_A_W){1'b0}}, mul_a} * {{(RANK_W-EXTENT_W){1'b0}}, mul_b};
   assign d_sq  = {{TRIAL_W{1'b0}}, d_ff} * {{TRIAL_W{1'b0}}, d_ff};

   always_comb begin
      if (ext_z_ff >= ext_x_ff && ext_z_ff >= ext_y_ff) begin
         axis_pick = AXIS_Z;
      end else if (ext_y_ff >= ext_x_ff && ext_y_ff >= ext_z_ff) begin
         axis_pick = AXIS_Y;
      end else begin
         axis_pick = AXIS_X;
      end
      case (axis_ff)
         AXIS_X:  ext_sel = ext_x_ff;
         AXIS_Y:  ext_sel = ext_y_ff;
         AXIS_Z:  ext_sel = ext_z_ff;
         default: ext_sel = ext_x_ff;
      endcase
      p_pick    = (n_ff > EXTENT_W'(1)) ? n_ff : best_ff;
      csr_value = (csr_wdata > EXTENT_LIMIT) ? EXTENT_LIMIT : csr_wdata;
   end

   always_comb begin
      state_in      = state_ff;
      grid_x_in     = grid_x_ff;
      grid_y_in     = grid_y_ff;
      grid_z_in     = grid_z_ff;
      ext_x_in      = ext_x_ff;
      ext_y_in      = ext_y_ff;
      ext_z_in      = ext_z_ff;
      coord_x_in    = coord_x_ff;
      coord_y_in    = coord_y_ff;
      coord_z_in    = coord_z_ff;
      rank_in       = rank_ff;
      size_in       = size_ff;
      axis_in       = axis_ff;
      n_in          = n_ff;
      d_in          = d_ff;
      best_in       = best_ff;
      p_in          = p_ff;
      reduced_in    = reduced_ff;
      q_in          = q_ff;
      rsp_strobe_in = 1'b0;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;
      rsp_oor_in    = rsp_oor_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_req       = '0;
      div_dividend  = '0;
      div_divisor   = '0;

      if (csr_we) begin
         case (csr_index)
            REG_GRID_SIZE_X: grid_x_in = csr_value;
            REG_GRID_SIZE_Y: grid_y_in = csr_value;
            REG_GRID_SIZE_Z: grid_z_in = csr_value;
            default:         ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rank_in    = req_process_rank;
               ext_x_in   = grid_x_ff;
               ext_y_in   = grid_y_ff;
               ext_z_in   = grid_z_ff;
               coord_x_in = '0;
               coord_y_in = '0;
               coord_z_in = '0;
               state_in   = S_SIZE_XY;
            end
         end
         S_SIZE_XY: begin
            mul_a    = MUL_A_W'(ext_x_ff);
            mul_b    = ext_y_ff;
            size_in  = mul_p;
            state_in = S_SIZE_Z;
         end
         S_SIZE_Z: begin
            mul_a    = size_ff[MUL_A_W-1:0];
            mul_b    = ext_z_ff;
            size_in  = mul_p;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (rank_ff >= size_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_x_in      = '0;
               rsp_y_in      = '0;
               rsp_z_in      = '0;
               rsp_oor_in    = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_LEVEL;
            end
         end
         S_LEVEL: begin
            if (size_ff <= RANK_W'(1)) begin
               rsp_strobe_in = 1'b1;
               rsp_x_in      = coord_x_ff;
               rsp_y_in      = coord_y_ff;
               rsp_z_in      = coord_z_ff;
               rsp_oor_in    = 1'b0;
               state_in      = S_IDLE;
            end else begin
               axis_in = axis_pick;
               case (axis_pick)
                  AXIS_X:  n_in = ext_x_ff;
                  AXIS_Y:  n_in = ext_y_ff;
                  AXIS_Z:  n_in = ext_z_ff;
                  default: n_in = ext_x_ff;
               endcase
               d_in     = TRIAL_W'(2);
               best_in  = EXTENT_W'(1);
               state_in = S_TRIAL;
            end
         end
         S_TRIAL: begin
            if (d_sq <= {2'b00, n_ff}) begin
               div_req.start = 1'b1;
               div_dividend  = DIV_W'(n_ff);
               div_divisor   = DIV_W'(d_ff);
               state_in      = S_TRIAL_WAIT;
            end else begin
               p_in          = p_pick;
               div_req.start = 1'b1;
               div_dividend  = DIV_W'(ext_sel);
               div_divisor   = DIV_W'(p_pick);
               state_in      = S_RED_WAIT;
            end
         end
         S_TRIAL_WAIT: begin
            if (div_done) begin
               if (div_remainder == '0) begin
                  best_in = EXTENT_W'(d_ff);
                  n_in    = div_quotient[EXTENT_W-1:0];
               end else begin
                  d_in = d_ff + TRIAL_W'(1);
               end
               state_in = S_TRIAL;
            end
         end
         S_RED_WAIT: begin
            if (div_done) begin
               reduced_in    = div_quotient[EXTENT_W-1:0];
               div_req.start = 1'b1;
               div_req.wide  = 1'b1;
               div_dividend  = size_ff;
               div_divisor   = DIV_W'(p_ff);
               state_in      = S_CSIZE_WAIT;
            end
         end
         S_CSIZE_WAIT: begin
            if (div_done) begin
               size_in       = div_quotient;
               div_req.start = 1'b1;
               div_req.wide  = 1'b1;
               div_dividend  = rank_ff;
               div_divisor   = div_quotient;
               state_in      = S_Q_WAIT;
            end
         end
         S_Q_WAIT: begin
            if (div_done) begin
               q_in     = div_quotient[EXTENT_W-1:0];
               rank_in  = div_remainder;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            mul_a = MUL_A_W'(q_ff);
            mul_b = reduced_ff;
            case (axis_ff)
               AXIS_X: begin
                  coord_x_in = coord_x_ff + mul_p[EXTENT_W-1:0];
                  ext_x_in   = reduced_ff;
               end
               AXIS_Y: begin
                  coord_y_in = coord_y_ff + mul_p[EXTENT_W-1:0];
                  ext_y_in   = reduced_ff;
               end
               AXIS_Z: begin
                  coord_z_in = coord_z_ff + mul_p[EXTENT_W-1:0];
                  ext_z_in   = reduced_ff;
               end
               default: ;
            endcase
            state_in = S_LEVEL;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         grid_x_ff     <= EXTENT_W'(1);
         grid_y_ff     <= EXTENT_W'(1);
         grid_z_ff     <= EXTENT_W'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         grid_x_ff     <= grid_x_in;
         grid_y_ff     <= grid_y_in;
         grid_z_ff     <= grid_z_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      ext_x_ff   <= ext_x_in;
      ext_y_ff   <= ext_y_in;
      ext_z_ff   <= ext_z_in;
      coord_x_ff <= coord_x_in;
      coord_y_ff <= coord_y_in;
      coord_z_ff <= coord_z_in;
      rank_ff    <= rank_in;
      size_ff    <= size_in;
      axis_ff    <= axis_in;
      n_ff       <= n_in;
      d_ff       <= d_in;
      best_ff    <= best_in;
      p_ff       <= p_in;
      reduced_ff <= reduced_in;
      q_ff       <= q_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
      rsp_oor_ff <= rsp_oor_in;
   end

   assign busy                  = (state_ff != S_IDLE);
   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_coord_x           = rsp_x_ff;
   assign rsp_coord_y           = rsp_y_ff;
   assign rsp_coord_z           = rsp_z_ff;
   assign rsp_rank_out_of_range = rsp_oor_ff;

endmodule

`default_nettype wire

@@ rtl/rtgc_div.sv @@
// ----------------------------------------------------------------------------
// rtgc_div
// Restoring divider, one quotient bit per cycle, 10 or 30 bit dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module rtgc_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rtgc_pkg::div_req_type       req,
   input  wire logic [rtgc_pkg::DIV_W-1:0]  dividend,
   input  wire logic [rtgc_pkg::DIV_W-1:0]  divisor,
   output logic                             done,
   output logic [rtgc_pkg::DIV_W-1:0]       quotient,
   output logic [rtgc_pkg::DIV_W-1:0]       remainder
);
   import rtgc_pkg::*;

   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [DIV_W-1:0]     dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_W:0]       rem_shift;
   logic [DIV_W+1:0]     diff;
   logic                 fits;

   always_comb begin
      rem_shift = {rem_ff, dvd_ff[DIV_W-1]};
      diff      = {1'b0, rem_shift} - {2'b00, dsr_ff};
      fits      = !diff[DIV_W+1];

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;

      if (req.start) begin
         dsr_in = divisor;
         rem_in = '0;
         quo_in = '0;
         run_in = 1'b1;
         if (req.wide) begin
            dvd_in = dividend;
            cnt_in = DIV_CNT_W'(DIV_W - 1);
         end else begin
            dvd_in = {dividend[DIV_SHORT_W-1:0], (DIV_W-DIV_SHORT_W)'(0)};
            cnt_in = DIV_CNT_W'(DIV_SHORT_W - 1);
         end
      end else if (run_ff) begin
         rem_in = fits ? diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ rtl/rtgc_checker.sv @@
// ----------------------------------------------------------------------------
// rtgc_checker
// Port-level checks of the transaction sequence of the grid coordinate mapper.
// ----------------------------------------------------------------------------
`default_nettype none

module rtgc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic                           rsp_strobe,
   input wire logic [rtgc_pkg::EXTENT_W-1:0]  rsp_coord_x,
   input wire logic [rtgc_pkg::EXTENT_W-1:0]  rsp_coord_y,
   input wire logic [rtgc_pkg::EXTENT_W-1:0]  rsp_coord_z,
   input wire logic                           rsp_rank_out_of_range
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while a transaction is still in work");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a transaction in work");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result repeated");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_rank_out_of_range |->
         rsp_coord_x == '0 && rsp_coord_y == '0 && rsp_coord_z == '0)
      else $error("out-of-range rank with nonzero coordinates");

endmodule

bind rank_to_grid_coordinates rtgc_checker u_rtgc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .start                 (start),
   .busy                  (busy),
   .rsp_strobe            (rsp_strobe),
   .rsp_coord_x           (rsp_coord_x),
   .rsp_coord_y           (rsp_coord_y),
   .rsp_coord_z           (rsp_coord_z),
   .rsp_rank_out_of_range (rsp_rank_out_of_range)
);

`default_nettype wire
